// File: rtl/core/ofr_pkg.sv
// Shared constants and axis-ordering helpers for the orthonormal frame pipeline.
package ofr_pkg;

	localparam int CoordWidthDef  = 32;
	localparam int OutFracBitsDef = 30;
	// Latency of the pipelined multiplier, in cycles.
	localparam int MulLat         = 5;
	// Width of one partial-product slice.
	localparam int Chunk          = 32;

	localparam logic [2:0] FUNC_XY = 3'd0;
	localparam logic [2:0] FUNC_YZ = 3'd1;
	localparam logic [2:0] FUNC_ZX = 3'd2;
	localparam logic [2:0] FUNC_YX = 3'd3;
	localparam logic [2:0] FUNC_XZ = 3'd4;
	localparam logic [2:0] FUNC_ZY = 3'd5;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	function automatic logic [1:0] prim_axis(input logic [2:0] f);
		case (f)
			FUNC_XY: return AXIS_X;
			FUNC_YZ: return AXIS_Y;
			FUNC_ZX: return AXIS_Z;
			FUNC_YX: return AXIS_Y;
			FUNC_XZ: return AXIS_X;
			FUNC_ZY: return AXIS_Z;
			default: return AXIS_X;
		endcase
	endfunction

	function automatic logic [1:0] sec_axis(input logic [2:0] f);
		case (f)
			FUNC_XY: return AXIS_Y;
			FUNC_YZ: return AXIS_Z;
			FUNC_ZX: return AXIS_X;
			FUNC_YX: return AXIS_X;
			FUNC_XZ: return AXIS_Z;
			FUNC_ZY: return AXIS_Y;
			default: return AXIS_Y;
		endcase
	endfunction

endpackage

// File: rtl/core/ofr_dly.sv
// Enabled shift register that carries side data alongside the arithmetic pipeline.
module ofr_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] pipe_s [D];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= d;
			for (int k = 1; k < D; k++) begin
				pipe_s[k] <= pipe_s[k-1];
			end
		end
	end

	assign q = pipe_s[D-1];
endmodule

// File: rtl/core/ofr_mul.sv
// Pipelined signed multiplier built from 32x32 partial products.
module ofr_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [WA-1:0] a,
	input  logic signed [WB-1:0] b,
	output logic signed [WA+WB-1:0] p
);
	import ofr_pkg::*;

	localparam int NA = (WA + Chunk - 1) / Chunk;
	localparam int NB = (WB + Chunk - 1) / Chunk;
	localparam int RW = (NB + 1) * Chunk;
	localparam int TW = (NA + NB) * Chunk;
	localparam int PW = WA + WB;

	logic [WA-1:0]         abs_a;
	logic [WB-1:0]         abs_b;
	logic [NA*Chunk-1:0]   ma_s1;
	logic [NB*Chunk-1:0]   mb_s1;
	logic                  sg_s1, sg_s2, sg_s3, sg_s4;
	logic [2*Chunk-1:0]    pp_s2 [NA][NB];
	logic [RW-1:0]         row_c [NA];
	logic [RW-1:0]         row_s3 [NA];
	logic [TW-1:0]         sum_c;
	logic [TW-1:0]         sum_s4;
	logic signed [PW-1:0]  p_s5;

	assign abs_a = a[WA-1] ? WA'(~a + 1'b1) : WA'(a);
	assign abs_b = b[WB-1] ? WB'(~b + 1'b1) : WB'(b);

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s2[i][j]) << (Chunk * j));
			end
		end
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (TW'(row_s3[i]) << (Chunk * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= (NA*Chunk)'(abs_a);
			mb_s1 <= (NB*Chunk)'(abs_b);
			sg_s1 <= a[WA-1] ^ b[WB-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= (2*Chunk)'(ma_s1[Chunk*i +: Chunk])
						* (2*Chunk)'(mb_s1[Chunk*j +: Chunk]);
				end
			end
			sg_s2  <= sg_s1;
			row_s3 <= row_c;
			sg_s3  <= sg_s2;
			sum_s4 <= sum_c;
			sg_s4  <= sg_s3;
			p_s5   <= sg_s4 ? -$signed(sum_s4[PW-1:0]) : $signed(sum_s4[PW-1:0]);
		end
	end

	assign p = p_s5;
endmodule

// File: rtl/core/ofr_root.sv
// Bit-per-stage search for floor(sqrt(w * 4^(F+1) / n)) using only shifts, adds, subtracts and compares.
module ofr_root #(
	parameter int SQW = 63,
	parameter int NW  = 65,
	parameter int F   = 30
) (
	input  logic           clk,
	input  logic           en,
	input  logic [SQW-1:0] w,
	input  logic [NW-1:0]  n,
	output logic [F+1:0]   z
);
	localparam int ZB = F + 2;
	localparam int KW = NW + 2*F + 5;

	// r holds the remainder w*4^(F+1) - z^2*n, y holds z*n.
	logic [KW-1:0] r_s [ZB];
	logic [KW-1:0] y_s [ZB];
	logic [ZB-1:0] z_s [ZB];
	logic [NW-1:0] n_s [ZB];

	for (genvar k = 0; k < ZB; k++) begin : g_bit
		localparam int B = ZB - 1 - k;
		logic [KW-1:0] rp, yp, delta;
		logic [ZB-1:0] zp;
		logic [NW-1:0] np;
		logic          take;

		if (k == 0) begin : g_first
			assign rp = KW'(w) << (2*F + 2);
			assign yp = '0;
			assign zp = '0;
			assign np = n;
		end else begin : g_next
			assign rp = r_s[k-1];
			assign yp = y_s[k-1];
			assign zp = z_s[k-1];
			assign np = n_s[k-1];
		end

		// Setting bit B grows z^2*n by 2^(B+1)*z*n + 4^B*n.
		assign delta = (yp << (B + 1)) + (KW'(np) << (2*B));
		assign take  = delta <= rp;

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= take ? rp - delta : rp;
				y_s[k] <= take ? yp + (KW'(np) << B) : yp;
				z_s[k] <= take ? (zp | (ZB'(1) << B)) : zp;
				n_s[k] <= np;
			end
		end
	end

	assign z = z_s[ZB-1];
endmodule

// File: rtl/core/ofr_col.sv
// One unit column: squares, norm, three rounding root lanes and sign restore.
module ofr_col #(
	parameter int M = 32,
	parameter int F = 30
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [M-1:0] v [3],
	input  logic                flip,
	output logic signed [F+1:0] col [3]
);
	import ofr_pkg::*;

	localparam int SQW = 2*M - 1;
	localparam int NW  = SQW + 2;
	localparam int ZB  = F + 2;
	localparam int LC  = MulLat + ZB + 2;

	logic signed [2*M-1:0] sq [3];
	logic [SQW-1:0]        w_s1 [3];
	logic [NW-1:0]         norm_s1;
	logic [ZB-1:0]         z [3];
	logic [3:0]            sgn_in, sgn_d;
	logic signed [F+1:0]   col_s2 [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		ofr_mul #(.WA(M), .WB(M)) u_sq (
			.clk(clk), .en(en), .a(v[i]), .b(v[i]), .p(sq[i])
		);
		ofr_root #(.SQW(SQW), .NW(NW), .F(F)) u_root (
			.clk(clk), .en(en), .w(w_s1[i]), .n(norm_s1), .z(z[i])
		);
	end

	assign sgn_in = {flip, v[2][M-1], v[1][M-1], v[0][M-1]};

	ofr_dly #(.W(4), .D(LC-1)) u_sgn (.clk(clk), .en(en), .d(sgn_in), .q(sgn_d));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i] <= sq[i][SQW-1:0];
			end
			norm_s1 <= NW'(sq[0][SQW-1:0]) + NW'(sq[1][SQW-1:0]) + NW'(sq[2][SQW-1:0]);
		end
	end

	// Round to nearest: q = (z + 1) / 2, where z is the doubled scaled value.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [ZB:0]   zp1;
				logic [ZB-1:0] q;
				zp1 = {1'b0, z[i]} + 1'b1;
				q   = zp1[ZB:1];
				col_s2[i] <= (sgn_d[i] ^ sgn_d[3]) ? -$signed(q) : $signed(q);
			end
		end
	end

	assign col = col_s2;
endmodule

// File: rtl/core/orthonormal_frame_from_two_vectors_top.sv
// Throughput: one beat per cycle; the whole pipeline advances unless the output beat is held.
// Bubbles move forward while the output waits empty, so a new beat can enter then.
// Reset clears only the valid chain; the data path holds no state between beats.
// Frame assembly: input regs, cross products, squared norms, per-bit root stages, placement.
module orthonormal_frame_from_two_vectors_top #(
	parameter int COORD_WIDTH   = ofr_pkg::CoordWidthDef,
	parameter int OUT_FRAC_BITS = ofr_pkg::OutFracBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   func,
	input  logic signed [COORD_WIDTH-1:0] primary_x,
	input  logic signed [COORD_WIDTH-1:0] primary_y,
	input  logic signed [COORD_WIDTH-1:0] primary_z,
	input  logic signed [COORD_WIDTH-1:0] secondary_x,
	input  logic signed [COORD_WIDTH-1:0] secondary_y,
	input  logic signed [COORD_WIDTH-1:0] secondary_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [OUT_FRAC_BITS+1:0] r00,
	output logic signed [OUT_FRAC_BITS+1:0] r01,
	output logic signed [OUT_FRAC_BITS+1:0] r02,
	output logic signed [OUT_FRAC_BITS+1:0] r10,
	output logic signed [OUT_FRAC_BITS+1:0] r11,
	output logic signed [OUT_FRAC_BITS+1:0] r12,
	output logic signed [OUT_FRAC_BITS+1:0] r20,
	output logic signed [OUT_FRAC_BITS+1:0] r21,
	output logic signed [OUT_FRAC_BITS+1:0] r22,
	output logic                         degenerate
);
	import ofr_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int F   = OUT_FRAC_BITS;
	localparam int OW  = F + 2;
	localparam int CCW = 2*CW + 1;
	localparam int DW  = 3*CW + 1;
	localparam int TC  = MulLat + 2;
	localparam int TD  = TC + MulLat + 1;
	localparam int LC  = MulLat + F + 4;
	localparam int L   = TD + LC + 1;
	localparam logic signed [OW-1:0] ONE = OW'(1) << F;

	logic           en;
	logic [L-1:0]   vld_q;

	logic [2:0]              func_s1;
	logic signed [CW-1:0]    p_s1 [3];
	logic signed [CW-1:0]    s_s1 [3];
	logic signed [2*CW-1:0]  u1 [3], v1 [3];
	logic signed [CCW-1:0]   c_s2 [3];
	logic [3*CW-1:0]         pc_flat;
	logic signed [CW-1:0]    pc [3];
	logic signed [DW-1:0]    u2 [3], v2 [3];
	logic signed [DW-1:0]    d_s3 [3];
	logic [3*CW-1:0]         pd_flat;
	logic signed [CW-1:0]    pd [3];
	logic [3*CCW-1:0]        cd_flat;
	logic signed [CCW-1:0]   cd [3];
	logic                    deg1, deg1_d, deg2, deg_o;
	logic [2:0]              func_d, func_o;
	logic                    flip;
	logic signed [OW-1:0]    colp [3], cols [3], colt [3];
	logic [1:0]              pa, sa, ta;
	logic signed [OW-1:0]    mat [3][3];
	logic signed [OW-1:0]    mat_s4 [3][3];
	logic                    deg_s4;

	assign en       = !vld_q[L-1] || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			p_s1[0] <= primary_x;
			p_s1[1] <= primary_y;
			p_s1[2] <= primary_z;
			s_s1[0] <= secondary_x;
			s_s1[1] <= secondary_y;
			s_s1[2] <= secondary_z;
		end
	end

	assign deg1 = (p_s1[0] == '0 && p_s1[1] == '0 && p_s1[2] == '0) || (func_s1 > FUNC_ZY);

	// c = p x s
	for (genvar i = 0; i < 3; i++) begin : g_cross1
		ofr_mul #(.WA(CW), .WB(CW)) u_a (
			.clk(clk), .en(en), .a(p_s1[(i+1)%3]), .b(s_s1[(i+2)%3]), .p(u1[i])
		);
		ofr_mul #(.WA(CW), .WB(CW)) u_b (
			.clk(clk), .en(en), .a(p_s1[(i+2)%3]), .b(s_s1[(i+1)%3]), .p(v1[i])
		);
	end

	ofr_dly #(.W(3*CW), .D(TC-1)) u_pc (
		.clk(clk), .en(en), .d({p_s1[2], p_s1[1], p_s1[0]}), .q(pc_flat)
	);
	ofr_dly #(.W(1), .D(TC-1)) u_deg1 (.clk(clk), .en(en), .d(deg1), .q(deg1_d));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= CCW'(u1[i]) - CCW'(v1[i]);
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_unpack_pc
		assign pc[i] = $signed(pc_flat[CW*i +: CW]);
	end

	assign deg2 = deg1_d || (c_s2[0] == '0 && c_s2[1] == '0 && c_s2[2] == '0);

	// d = c x p, the secondary direction with the primary component removed.
	for (genvar i = 0; i < 3; i++) begin : g_cross2
		ofr_mul #(.WA(CCW), .WB(CW)) u_a (
			.clk(clk), .en(en), .a(c_s2[(i+1)%3]), .b(pc[(i+2)%3]), .p(u2[i])
		);
		ofr_mul #(.WA(CCW), .WB(CW)) u_b (
			.clk(clk), .en(en), .a(c_s2[(i+2)%3]), .b(pc[(i+1)%3]), .p(v2[i])
		);
	end

	ofr_dly #(.W(3*CW), .D(MulLat+1)) u_pd (.clk(clk), .en(en), .d(pc_flat), .q(pd_flat));
	ofr_dly #(.W(3*CCW), .D(MulLat+1)) u_cd (
		.clk(clk), .en(en), .d({c_s2[2], c_s2[1], c_s2[0]}), .q(cd_flat)
	);
	ofr_dly #(.W(1), .D(TD+LC-TC)) u_deg2 (.clk(clk), .en(en), .d(deg2), .q(deg_o));
	ofr_dly #(.W(3), .D(TD-1)) u_fd (.clk(clk), .en(en), .d(func_s1), .q(func_d));
	ofr_dly #(.W(3), .D(LC)) u_fo (.clk(clk), .en(en), .d(func_d), .q(func_o));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s3[i] <= u2[i] - v2[i];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_unpack_d
		assign pd[i] = $signed(pd_flat[CW*i +: CW]);
		assign cd[i] = $signed(cd_flat[CCW*i +: CCW]);
	end

	// Non-cyclic orderings need the negated cross product for a right-handed frame.
	assign flip = func_d >= FUNC_YX;

	ofr_col #(.M(CW), .F(F)) u_colp (
		.clk(clk), .en(en), .v(pd), .flip(1'b0), .col(colp)
	);
	ofr_col #(.M(DW), .F(F)) u_cols (
		.clk(clk), .en(en), .v(d_s3), .flip(1'b0), .col(cols)
	);
	ofr_col #(.M(CCW), .F(F)) u_colt (
		.clk(clk), .en(en), .v(cd), .flip(flip), .col(colt)
	);

	assign pa = prim_axis(func_o);
	assign sa = sec_axis(func_o);
	assign ta = 2'd3 - pa - sa;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mat[i][j] = '0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			mat[i][pa] = colp[i];
			mat[i][sa] = cols[i];
			mat[i][ta] = colt[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mat_s4[i][j] <= deg_o ? '0 : mat[i][j];
				end
			end
			deg_s4 <= deg_o;
		end
	end

	assign out_valid  = vld_q[L-1];
	assign r00        = mat_s4[0][0];
	assign r01        = mat_s4[0][1];
	assign r02        = mat_s4[0][2];
	assign r10        = mat_s4[1][0];
	assign r11        = mat_s4[1][1];
	assign r12        = mat_s4[1][2];
	assign r20        = mat_s4[2][0];
	assign r21        = mat_s4[2][1];
	assign r22        = mat_s4[2][2];
	assign degenerate = deg_s4;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> r00 == '0 && r01 == '0 && r02 == '0 && r10 == '0
			&& r11 == '0 && r12 == '0 && r20 == '0 && r21 == '0 && r22 == '0)
		else $error("degenerate beat carries a nonzero matrix");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> r00 <= ONE && r00 >= -ONE && r11 <= ONE
			&& r11 >= -ONE && r22 <= ONE && r22 >= -ONE)
		else $error("matrix element outside unit range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("held output beat was lost");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output beat");
endmodule
